// ===== design/bcs_pkg.sv =====
// Shared types and constants for the Bezier curve sampler.
// No dependencies; imported by every module of the block.
package bcs_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W     = 32;
  localparam int SAMPLE_W    = 16;
  localparam int PCOUNT_W    = 4;
  localparam int PIDX_W      = 3;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 112;

  localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 16'd64;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [1:0] {
    COORD_X,
    COORD_Y,
    COORD_Z
  } coord_t;

  typedef struct packed {
    coord_t coord;
    logic   last;
  } lerp_tag_t;

endpackage

// ===== design/bcs_tdiv.sv =====
// Restoring divider for the curve parameter t = floor(i * 2^FRAC_BITS / count).
// One quotient bit per cycle. Depends on bcs_pkg.
module bcs_tdiv #(
  parameter int FRAC_BITS = bcs_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [bcs_pkg::SAMPLE_W-1:0] idx_i,
  input  logic [bcs_pkg::SAMPLE_W-1:0] count_i,
  output logic [FRAC_BITS:0]           t_o,
  output logic                         done_o
);
  import bcs_pkg::*;

  localparam int CNTW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [SAMPLE_W-1:0] rem_r, div_r, rem_nxt;
  logic [SAMPLE_W:0]   trial, trial_sub;
  logic [FRAC_BITS:0]  t_r;
  logic [CNTW-1:0]     cnt_r;
  logic                busy_r, done_r, ge;

  assign trial     = {rem_r, 1'b0};
  assign ge        = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};
  assign rem_nxt   = ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start_i) begin
        priority if (count_i == '0) begin
          t_r    <= '0;
          done_r <= 1'b1;
        end else if (idx_i == count_i) begin
          t_r    <= T_ONE;
          done_r <= 1'b1;
        end else begin
          rem_r  <= idx_i;
          div_r  <= count_i;
          t_r    <= '0;
          cnt_r  <= CNTW'(FRAC_BITS);
          busy_r <= 1'b1;
          done_r <= 1'b0;
        end
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        t_r    <= {t_r[FRAC_BITS-1:0], ge};
        cnt_r  <= cnt_r - CNTW'(1);
        busy_r <= (cnt_r != CNTW'(1));
        done_r <= (cnt_r == CNTW'(1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign t_o    = t_r;
  assign done_o = done_r;

endmodule

// ===== design/bcs_lerp.sv =====
// Shared interpolation unit: a + floor((b - a) * t / 2^FRAC_BITS).
// Two stages: multiply, then shift and add. Depends on bcs_pkg.
module bcs_lerp #(
  parameter int FRAC_BITS = bcs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid_i,
  input  bcs_pkg::lerp_tag_t                 in_tag_i,
  input  logic signed [bcs_pkg::COORD_W-1:0] a_i,
  input  logic signed [bcs_pkg::COORD_W-1:0] b_i,
  input  logic [FRAC_BITS:0]                 t_i,
  output logic                               res_valid_o,
  output bcs_pkg::lerp_tag_t                 res_tag_o,
  output logic signed [bcs_pkg::COORD_W-1:0] res_o
);
  import bcs_pkg::*;

  localparam int PW = COORD_W + FRAC_BITS + 3;

  logic signed [COORD_W:0]     diff_w;
  logic signed [FRAC_BITS+1:0] t_w;
  logic signed [PW-1:0]        prod_nxt, prod_r, shifted;
  logic signed [COORD_W-1:0]   a_r;
  lerp_tag_t                   tag_r;
  logic                        valid_r;

  // 33-bit signed difference times 18-bit signed t
  assign diff_w   = (COORD_W+1)'(b_i) - (COORD_W+1)'(a_i);
  assign t_w      = {1'b0, t_i};
  assign prod_nxt = diff_w * t_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid_i;
    end
    prod_r <= prod_nxt;
    a_r    <= a_i;
    tag_r  <= in_tag_i;
  end

  assign shifted     = prod_r >>> FRAC_BITS;
  assign res_o       = a_r + shifted[COORD_W-1:0];
  assign res_valid_o = valid_r;
  assign res_tag_o   = tag_r;

endmodule

// ===== design/bezier_curve_sampler_top.sv =====
// Bezier curve sampler, top level: point store, t divider and de Casteljau sequencer
// around one shared multiply/add unit. Depends on bcs_pkg, bcs_tdiv, bcs_lerp.
// An evaluation of n points first computes t in the divider (shortcut when sample_count
// is 0 or the saturated index equals it), then issues 3*n*(n-1)/2 lerp operations, drains
// the lerp unit and registers the result. Ready only while idle; a held result delays
// the next one. Sync active-low reset: point_count 0, sample_count 64, point store kept.
module bezier_curve_sampler_top #(
  parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_index[2:0], coord_x[34:3], coord_y[66:35], coord_z[98:67],
  // sample_index[114:99], zero fill
  input  logic [bcs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sample_number[15:0], curve_x[47:16], curve_y[79:48], curve_z[111:80]
  output logic [bcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [bcs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bcs_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] N_MAX = CW'(MAX_POINTS);
  localparam logic [CW-1:0] N_TWO = CW'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // input fields
  logic [PIDX_W-1:0]   in_pidx;
  logic [COORD_W-1:0]  in_x, in_y, in_z;
  logic [SAMPLE_W-1:0] in_sidx;

  assign in_pidx = in_tdata[PIDX_W-1:0];
  assign in_x    = in_tdata[PIDX_W +: COORD_W];
  assign in_y    = in_tdata[PIDX_W + COORD_W +: COORD_W];
  assign in_z    = in_tdata[PIDX_W + 2*COORD_W +: COORD_W];
  assign in_sidx = in_tdata[PIDX_W + 3*COORD_W +: SAMPLE_W];

  // configuration
  logic [PCOUNT_W-1:0] pc_r;
  logic [SAMPLE_W-1:0] sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      sc_r <= SAMPLE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POINT_COUNT:  pc_r <= cfg_wdata[PCOUNT_W-1:0];
        REG_SAMPLE_COUNT: sc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t              state_r;
  logic                in_acc, load_ok, eval_go;
  logic [CW-1:0]       n_eff;
  logic [SAMPLE_W-1:0] sat_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign n_eff     = (32'(pc_r) > MAX_POINTS) ? N_MAX : CW'(pc_r);
  assign load_ok   = 32'(in_pidx) < MAX_POINTS;
  assign eval_go   = in_acc && (in_tuser == MODE_EVAL) && (n_eff >= N_TWO);
  assign sat_idx   = (in_sidx > sc_r) ? sc_r : in_sidx;

  // t divider
  logic [FRAC_BITS:0] div_t;
  logic               div_done;

  bcs_tdiv #(.FRAC_BITS(FRAC_BITS)) u_tdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (eval_go),
    .idx_i   (sat_idx),
    .count_i (sc_r),
    .t_o     (div_t),
    .done_o  (div_done)
  );

  // sequencer registers
  logic [IW-1:0]       i_r;
  logic [CW-1:0]       cur_r;
  coord_t              coord_r;
  logic                first_r, issuing_r, issue;
  logic [SAMPLE_W-1:0] samp_r;
  logic [COORD_W-1:0]  cx_r, cy_r, cz_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [IW-1:0] rd_a, rd_b;
  assign issue = (state_r == ST_EVAL) && issuing_r;
  assign rd_a  = i_r;
  assign rd_b  = i_r + IW'(1);

  // point store and working memories
  logic [3*COORD_W-1:0] store_mem [MAX_POINTS];
  logic [COORD_W-1:0]   work_x [MAX_POINTS];
  logic [COORD_W-1:0]   work_y [MAX_POINTS];
  logic [COORD_W-1:0]   work_z [MAX_POINTS];
  logic [3*COORD_W-1:0] st_a_r, st_b_r;
  logic [COORD_W-1:0]   wx_a_r, wx_b_r, wy_a_r, wy_b_r, wz_a_r, wz_b_r;

  // lerp unit signals
  lerp_tag_t                 s0_tag_r, res_tag;
  logic                      s0_valid_r, s0_first_r, res_valid;
  logic [IW-1:0]             s0_idx_r, s1_idx_r;
  logic signed [COORD_W-1:0] op_a, op_b, res;

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_LOAD) && load_ok) begin
      store_mem[IW'(in_pidx)] <= {in_z, in_y, in_x};
    end
    st_a_r <= store_mem[rd_a];
    st_b_r <= store_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (res_valid && (res_tag.coord == COORD_X)) work_x[s1_idx_r] <= res;
    if (res_valid && (res_tag.coord == COORD_Y)) work_y[s1_idx_r] <= res;
    if (res_valid && (res_tag.coord == COORD_Z)) work_z[s1_idx_r] <= res;
    wx_a_r <= work_x[rd_a];
    wx_b_r <= work_x[rd_b];
    wy_a_r <= work_y[rd_a];
    wy_b_r <= work_y[rd_b];
    wz_a_r <= work_z[rd_a];
    wz_b_r <= work_z[rd_b];
  end

  // read stage tags, then index alongside the multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= issue;
    end
    s0_tag_r   <= '{coord: coord_r, last: (cur_r == N_TWO)};
    s0_first_r <= first_r;
    s0_idx_r   <= i_r;
    s1_idx_r   <= s0_idx_r;
  end

  always_comb begin
    unique case (s0_tag_r.coord)
      COORD_X: begin
        op_a = s0_first_r ? st_a_r[0 +: COORD_W] : wx_a_r;
        op_b = s0_first_r ? st_b_r[0 +: COORD_W] : wx_b_r;
      end
      COORD_Y: begin
        op_a = s0_first_r ? st_a_r[COORD_W +: COORD_W] : wy_a_r;
        op_b = s0_first_r ? st_b_r[COORD_W +: COORD_W] : wy_b_r;
      end
      COORD_Z: begin
        op_a = s0_first_r ? st_a_r[2*COORD_W +: COORD_W] : wz_a_r;
        op_b = s0_first_r ? st_b_r[2*COORD_W +: COORD_W] : wz_b_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bcs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (s0_valid_r),
    .in_tag_i    (s0_tag_r),
    .a_i         (op_a),
    .b_i         (op_b),
    .t_i         (div_t),
    .res_valid_o (res_valid),
    .res_tag_o   (res_tag),
    .res_o       (res)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != ST_FINISH)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (eval_go) begin
            samp_r  <= sat_idx;
            cur_r   <= n_eff;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            i_r       <= '0;
            coord_r   <= COORD_X;
            first_r   <= 1'b1;
            issuing_r <= 1'b1;
            state_r   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (issuing_r) begin
            unique case (coord_r)
              COORD_X: coord_r <= COORD_Y;
              COORD_Y: coord_r <= COORD_Z;
              default: begin
                coord_r <= COORD_X;
                if ((CW'(i_r) + N_TWO) == cur_r) begin
                  i_r     <= '0;
                  first_r <= 1'b0;
                  if (cur_r == N_TWO) begin
                    issuing_r <= 1'b0;
                  end else begin
                    cur_r <= cur_r - CW'(1);
                  end
                end else begin
                  i_r <= i_r + IW'(1);
                end
              end
            endcase
          end
          if (res_valid && res_tag.last) begin
            unique case (res_tag.coord)
              COORD_X: cx_r <= res;
              COORD_Y: cy_r <= res;
              default: begin
                cz_r    <= res;
                state_r <= ST_FINISH;
              end
            endcase
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {cz_r, cy_r, cx_r, samp_r};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/bcs_checker.sv =====
// Port-level checks for the Bezier curve sampler, bound to the top level.
// Depends on bcs_pkg and bezier_curve_sampler_top.
module bcs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bcs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction dropped or changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not leave block idle and empty");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after input transaction");

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_LOAD) |=> in_tready)
    else $error("load transaction made block busy");

endmodule

bind bezier_curve_sampler_top bcs_checker u_bcs_checker (.*);
